FILE: rtl/spi_flash_command_sequencer_unit_defines.svh
// assertion macros for the flash command sequencer
`ifndef SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SFCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication checked with the consequent in the cycle after the antecedent
`define SFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/sfcs_pkg.sv
// shared types, codes and constants of the flash command sequencer
package sfcs_pkg;
  localparam int unsigned ERASE_STEP = 4096;
  localparam logic [19:0] POLL_LIMIT_RESET = 20'd1000000;
  localparam logic [7:0] SPI_READ_ID = 8'h9F;
  localparam logic [7:0] SPI_READ_FAST = 8'h0B;
  localparam logic [7:0] SPI_ERASE_4K = 8'h20;
  localparam logic [7:0] SPI_PROGRAM = 8'h02;
  localparam logic [7:0] SPI_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] SPI_STATUS_READ = 8'h05;
  localparam logic [7:0] SPI_STATUS_ENABLE = 8'h50;
  localparam logic [7:0] SPI_STATUS_WRITE = 8'h01;

  localparam logic [2:0] REQ_DETECT = 3'd0;
  localparam logic [2:0] REQ_READ = 3'd1;
  localparam logic [2:0] REQ_ERASE = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_RX = 3'd4;
  localparam logic [2:0] REQ_DATA = 3'd5;

  localparam logic [2:0] KIND_XFER = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_ID = 3'd2;
  localparam logic [2:0] KIND_NEED = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_DET_WC = 5'd1;
  localparam logic [4:0] PH_DET_WS = 5'd2;
  localparam logic [4:0] PH_DET_ID = 5'd3;
  localparam logic [4:0] PH_RD_HDR = 5'd4;
  localparam logic [4:0] PH_RD_DATA = 5'd5;
  localparam logic [4:0] PH_WP1_WC = 5'd6;
  localparam logic [4:0] PH_WP1_WS = 5'd7;
  localparam logic [4:0] PH_WP_EWSR = 5'd8;
  localparam logic [4:0] PH_WP_WRSR = 5'd9;
  localparam logic [4:0] PH_WP2_WC = 5'd10;
  localparam logic [4:0] PH_WP2_WS = 5'd11;
  localparam logic [4:0] PH_WE_WC = 5'd12;
  localparam logic [4:0] PH_WE_WS = 5'd13;
  localparam logic [4:0] PH_WE_WREN = 5'd14;
  localparam logic [4:0] PH_PROG_HDR = 5'd15;
  localparam logic [4:0] PH_PROG_WC = 5'd16;
  localparam logic [4:0] PH_PROG_WS = 5'd17;
  localparam logic [4:0] PH_NEED_DATA = 5'd18;

  typedef struct packed {
    logic [2:0] req_type;
    logic [23:0] address;
    logic [24:0] length;
    logic [7:0] write_byte;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic frame_last;
    logic [7:0] data_byte;
    logic [7:0] manufacturer_id;
    logic [7:0] device_id;
    logic [7:0] capacity_id;
    logic id_ok;
    logic last;
  } res_t;

  // up to two words per input word
  typedef struct packed {
    logic [1:0] count;
    res_t r0;
    res_t r1;
  } res_pair_t;
endpackage

FILE: rtl/sfcs_if.sv
// valid/ready channel interfaces for requests and results
interface sfcs_req_if;
  logic valid;
  logic ready;
  sfcs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfcs_res_if;
  logic valid;
  logic ready;
  sfcs_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sfcs_core.sv
// sequencer state and next-state logic: one request word in, up to two result words out
module sfcs_core (
  input logic clk,
  input logic rst,
  input logic step,
  input sfcs_pkg::req_t req,
  input logic [19:0] poll_limit,
  output sfcs_pkg::res_pair_t res,
  output logic busy
);
  logic [1:0] op_kind, op_kind_next;
  logic busy_flag, busy_flag_next;
  logic [4:0] phase, phase_next;
  logic [2:0] frame_index, frame_index_next;
  logic [25:0] current_address, current_address_next;
  logic [25:0] end_address, end_address_next;
  logic [24:0] bytes_left, bytes_left_next;
  logic [19:0] poll_count, poll_count_next;
  logic [7:0] id0, id0_next, id1, id1_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic [19:0] poll_inc;
  logic [25:0] addr_inc;
  logic [24:0] left_dec;
  logic more_units;
  logic [7:0] abyte;
  logic [2:0] fi_inc;

  assign busy = busy_flag;
  assign poll_inc = poll_count + 20'd1;
  assign left_dec = bytes_left - 25'd1;
  assign fi_inc = frame_index + 3'd1;

  always_comb begin
    case (fi_inc[1:0])
      2'd1: abyte = current_address[23:16];
      2'd2: abyte = current_address[15:8];
      default: abyte = current_address[7:0];
    endcase
  end

  always_comb begin
    sfcs_pkg::res_t r0, r1;
    logic [1:0] n;
    logic adv;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    adv = 1'b0;
    op_kind_next = op_kind;
    busy_flag_next = busy_flag;
    phase_next = phase;
    frame_index_next = frame_index;
    current_address_next = current_address;
    end_address_next = end_address;
    bytes_left_next = bytes_left;
    poll_count_next = poll_count;
    id0_next = id0;
    id1_next = id1;
    pending_byte_next = pending_byte;
    addr_inc = current_address;
    more_units = 1'b0;

    if (!busy_flag) begin
      if (req.req_type <= sfcs_pkg::REQ_WRITE) begin
        busy_flag_next = 1'b1;
        op_kind_next = req.req_type[1:0];
        frame_index_next = 3'd0;
        current_address_next = {2'b00, req.address};
        end_address_next = {2'b00, req.address} + {1'b0, req.length};
        bytes_left_next = req.length;
        poll_count_next = '0;
        n = 2'd1;
        r0.kind = sfcs_pkg::KIND_XFER;
        if (req.req_type == sfcs_pkg::REQ_DETECT) begin
          phase_next = sfcs_pkg::PH_DET_WC;
          r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
        end else if (req.req_type == sfcs_pkg::REQ_READ) begin
          phase_next = sfcs_pkg::PH_RD_HDR;
          r0.tx_byte = sfcs_pkg::SPI_READ_FAST;
        end else begin
          phase_next = sfcs_pkg::PH_WP1_WC;
          r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
        end
      end
    end else if (req.req_type == sfcs_pkg::REQ_DATA && phase == sfcs_pkg::PH_NEED_DATA) begin
      pending_byte_next = req.write_byte;
      poll_count_next = '0;
      phase_next = sfcs_pkg::PH_WE_WC;
      n = 2'd1;
      r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
    end else if (req.req_type == sfcs_pkg::REQ_RX && phase != sfcs_pkg::PH_NEED_DATA
                 && phase != sfcs_pkg::PH_IDLE) begin
      case (phase)
        sfcs_pkg::PH_DET_WC, sfcs_pkg::PH_WP1_WC, sfcs_pkg::PH_WP2_WC,
        sfcs_pkg::PH_WE_WC, sfcs_pkg::PH_PROG_WC: begin
          phase_next = phase + 5'd1;
          n = 2'd1;
          r0.frame_last = 1'b1;
        end
        sfcs_pkg::PH_DET_WS, sfcs_pkg::PH_WP1_WS, sfcs_pkg::PH_WP2_WS,
        sfcs_pkg::PH_WE_WS, sfcs_pkg::PH_PROG_WS: begin
          poll_count_next = poll_inc;
          n = 2'd1;
          if (!req.rx_byte[0] || poll_inc >= poll_limit) begin
            case (phase)
              sfcs_pkg::PH_DET_WS: begin
                phase_next = sfcs_pkg::PH_DET_ID;
                frame_index_next = 3'd0;
                r0.tx_byte = sfcs_pkg::SPI_READ_ID;
              end
              sfcs_pkg::PH_WP1_WS: begin
                phase_next = sfcs_pkg::PH_WP_EWSR;
                r0.tx_byte = sfcs_pkg::SPI_STATUS_ENABLE;
                r0.frame_last = 1'b1;
              end
              sfcs_pkg::PH_WE_WS: begin
                phase_next = sfcs_pkg::PH_WE_WREN;
                r0.tx_byte = sfcs_pkg::SPI_WRITE_ENABLE;
                r0.frame_last = 1'b1;
              end
              sfcs_pkg::PH_WP2_WS: begin
                more_units = 1'b1;
              end
              default: begin
                adv = 1'b1;
                more_units = 1'b1;
              end
            endcase
          end else begin
            phase_next = phase - 5'd1;
            r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
          end
        end
        sfcs_pkg::PH_DET_ID: begin
          n = 2'd1;
          if (frame_index == 3'd0) begin
            frame_index_next = 3'd1;
          end else if (frame_index == 3'd1) begin
            id0_next = req.rx_byte;
            frame_index_next = 3'd2;
          end else if (frame_index == 3'd2) begin
            id1_next = req.rx_byte;
            frame_index_next = 3'd3;
            r0.frame_last = 1'b1;
          end else begin
            n = 2'd2;
            r0.kind = sfcs_pkg::KIND_ID;
            r0.manufacturer_id = id0;
            r0.device_id = id1;
            r0.capacity_id = req.rx_byte;
            r0.id_ok = (id0 != 8'h00) && (id0 != 8'hFF);
            r1.kind = sfcs_pkg::KIND_DONE;
            busy_flag_next = 1'b0;
            phase_next = sfcs_pkg::PH_IDLE;
            frame_index_next = 3'd0;
          end
        end
        sfcs_pkg::PH_RD_HDR: begin
          n = 2'd1;
          if (frame_index < 3'd3) begin
            frame_index_next = fi_inc;
            r0.tx_byte = abyte;
          end else if (frame_index == 3'd3) begin
            frame_index_next = 3'd4;
            r0.frame_last = (bytes_left == '0);
          end else if (bytes_left == '0) begin
            r0.kind = sfcs_pkg::KIND_DONE;
            busy_flag_next = 1'b0;
            phase_next = sfcs_pkg::PH_IDLE;
            frame_index_next = 3'd0;
          end else begin
            phase_next = sfcs_pkg::PH_RD_DATA;
            r0.frame_last = (bytes_left == 25'd1);
          end
        end
        sfcs_pkg::PH_RD_DATA: begin
          n = 2'd2;
          r0.kind = sfcs_pkg::KIND_DATA;
          r0.data_byte = req.rx_byte;
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            r1.kind = sfcs_pkg::KIND_DONE;
            busy_flag_next = 1'b0;
            phase_next = sfcs_pkg::PH_IDLE;
            frame_index_next = 3'd0;
          end else begin
            r1.frame_last = (left_dec == 25'd1);
          end
        end
        sfcs_pkg::PH_WP_EWSR: begin
          n = 2'd1;
          phase_next = sfcs_pkg::PH_WP_WRSR;
          frame_index_next = 3'd0;
          r0.tx_byte = sfcs_pkg::SPI_STATUS_WRITE;
        end
        sfcs_pkg::PH_WP_WRSR: begin
          n = 2'd1;
          if (frame_index == 3'd0) begin
            frame_index_next = 3'd1;
            r0.frame_last = 1'b1;
          end else begin
            poll_count_next = '0;
            phase_next = sfcs_pkg::PH_WP2_WC;
            r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
          end
        end
        sfcs_pkg::PH_WE_WREN: begin
          n = 2'd1;
          phase_next = sfcs_pkg::PH_PROG_HDR;
          frame_index_next = 3'd0;
          r0.tx_byte = (op_kind == sfcs_pkg::REQ_ERASE[1:0]) ? sfcs_pkg::SPI_ERASE_4K
                                                              : sfcs_pkg::SPI_PROGRAM;
        end
        sfcs_pkg::PH_PROG_HDR: begin
          n = 2'd1;
          if (frame_index < 3'd3) begin
            frame_index_next = fi_inc;
            r0.tx_byte = abyte;
            r0.frame_last = (op_kind == sfcs_pkg::REQ_ERASE[1:0]) && (fi_inc == 3'd3);
          end else if (frame_index == 3'd3 && op_kind == sfcs_pkg::REQ_WRITE[1:0]) begin
            frame_index_next = 3'd4;
            r0.tx_byte = pending_byte;
            r0.frame_last = 1'b1;
          end else begin
            poll_count_next = '0;
            phase_next = sfcs_pkg::PH_PROG_WC;
            r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
          end
        end
        default: begin
          n = 2'd0;
        end
      endcase

      // step to the next erase block or program byte, then pick the next unit
      if (adv) begin
        if (op_kind == sfcs_pkg::REQ_ERASE[1:0]) begin
          addr_inc = current_address + 26'(sfcs_pkg::ERASE_STEP);
        end else begin
          addr_inc = current_address + 26'd1;
          bytes_left_next = left_dec;
        end
        current_address_next = addr_inc;
      end
      if (more_units) begin
        if (op_kind == sfcs_pkg::REQ_ERASE[1:0]) begin
          if (addr_inc < end_address) begin
            poll_count_next = '0;
            phase_next = sfcs_pkg::PH_WE_WC;
            r0.tx_byte = sfcs_pkg::SPI_STATUS_READ;
          end else begin
            r0.kind = sfcs_pkg::KIND_DONE;
            busy_flag_next = 1'b0;
            phase_next = sfcs_pkg::PH_IDLE;
            frame_index_next = 3'd0;
          end
        end else if (bytes_left_next != '0) begin
          r0.kind = sfcs_pkg::KIND_NEED;
          phase_next = sfcs_pkg::PH_NEED_DATA;
        end else begin
          r0.kind = sfcs_pkg::KIND_DONE;
          busy_flag_next = 1'b0;
          phase_next = sfcs_pkg::PH_IDLE;
          frame_index_next = 3'd0;
        end
      end
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
    res.count = n;
    res.r0 = r0;
    res.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_kind <= '0;
      busy_flag <= 1'b0;
      phase <= sfcs_pkg::PH_IDLE;
      frame_index <= '0;
      current_address <= '0;
      end_address <= '0;
      bytes_left <= '0;
      poll_count <= '0;
    end else if (step) begin
      op_kind <= op_kind_next;
      busy_flag <= busy_flag_next;
      phase <= phase_next;
      frame_index <= frame_index_next;
      current_address <= current_address_next;
      end_address <= end_address_next;
      bytes_left <= bytes_left_next;
      poll_count <= poll_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      id0 <= id0_next;
      id1 <= id1_next;
      pending_byte <= pending_byte_next;
    end
  end
endmodule

FILE: rtl/sfcs_out_buf.sv
// two-entry result buffer that drains a word pair onto the result channel
module sfcs_out_buf (
  input logic clk,
  input logic rst,
  input logic load,
  input sfcs_pkg::res_pair_t pair,
  output logic can_load,
  sfcs_res_if.source res
);
  sfcs_pkg::res_t slot0, slot1;
  logic [1:0] fill;
  logic pop;

  assign res.valid = (fill != 2'd0);
  assign res.data = slot0;
  assign pop = res.valid && res.ready;
  // space for a full pair once the head word leaves
  assign can_load = (fill == 2'd0) || (fill == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load && can_load) begin
      fill <= pair.count;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      slot0 <= pair.r0;
      slot1 <= pair.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end
endmodule

FILE: rtl/spi_flash_command_sequencer_unit.sv
// top level of the flash command sequencer
// Usage:
// - req channel carries requests (detect, read, erase, write), returned spi
//   bytes and write data; res channel carries transfers, read data, id
//   reports, data requests and done words.
// - user writes poll_limit (cfg_we/cfg_data) while block idle; not enforced.
// - every input word is registered into a two-slot result buffer in the
//   same cycle it is taken; its first result word is visible the next cycle.
// - one input word per cycle while the receiver takes every word; a word
//   that makes two results stalls the input until its first result leaves.
// - a word is taken only when the result buffer is empty or its last
//   word leaves in that cycle, so a stalled receiver stalls the input.
// - words that cause no result are taken and dropped at the same rate.
// - reset (rst, synchronous) returns to idle with poll_limit 1000000 and
//   empties the result buffer.
// - erase walks 4K blocks, write asks for each data byte with a
//   need-write-data word and waits for it on the req channel.
`include "spi_flash_command_sequencer_unit_defines.svh"
module spi_flash_command_sequencer_unit (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [19:0] cfg_data,
  sfcs_req_if.sink req,
  sfcs_res_if.source res
);
  logic [19:0] poll_limit;
  logic step;
  logic can_load;
  logic busy;
  sfcs_pkg::res_pair_t pair;

  assign req.ready = can_load;
  assign step = req.valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= sfcs_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_data;
    end
  end

  sfcs_core u_core (
    .clk(clk),
    .rst(rst),
    .step(step),
    .req(req.data),
    .poll_limit(poll_limit),
    .res(pair),
    .busy(busy)
  );

  sfcs_out_buf u_buf (
    .clk(clk),
    .rst(rst),
    .load(step),
    .pair(pair),
    .can_load(can_load),
    .res(res)
  );

  `SFCS_ASSERT_IMPL(a_done_is_last, clk, rst,
    res.valid && res.data.kind == sfcs_pkg::KIND_DONE, res.data.last,
    "done word not marked last")
  `SFCS_ASSERT_NEXT(a_done_idle, clk, rst,
    step && pair.count != 2'd0 && pair.r0.kind == sfcs_pkg::KIND_DONE, !busy,
    "sequencer still busy after done")
  `SFCS_ASSERT_NEXT(a_idle_no_rx_result, clk, rst,
    step && !busy && req.data.req_type > sfcs_pkg::REQ_WRITE, $stable(busy),
    "returned byte started a sequence while idle")
endmodule
